@@ rtl/vector2_normalize_unit_macros.svh @@
// Assertion helpers shared by the vector normalize RTL.
`ifndef VECTOR2_NORMALIZE_UNIT_MACROS_SVH
`define VECTOR2_NORMALIZE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define V2N_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define V2N_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/v2n_pkg.sv @@
package v2n_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned INT_BITS_DEF  = 8;

  // Tolerance register: Q0.16, reset value one LSB.
  localparam int unsigned TOL_W = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Register index, taken from paddr above the byte offset.
  localparam logic [APB_ADDR_W-3:0] REG_TOLERANCE = 1'b0;

  // Control bits that travel with every beat down the pipeline.
  typedef struct packed {
    logic valid;
    logic neg_x;
    logic neg_y;
    logic degen;
  } v2n_tag_t;

endpackage

@@ rtl/v2n_sqrt_cell.sv @@
module v2n_sqrt_cell #(
  parameter int unsigned IN_W = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  v2n_pkg::v2n_tag_t     tag_i,
  input  logic [2*IN_W-1:0]     rad_i,
  input  logic [IN_W+1:0]       rem_i,
  input  logic [IN_W-1:0]       root_i,
  input  logic [IN_W-1:0]       ax_i,
  input  logic [IN_W-1:0]       ay_i,
  output v2n_pkg::v2n_tag_t     tag_o,
  output logic [2*IN_W-1:0]     rad_o,
  output logic [IN_W+1:0]       rem_o,
  output logic [IN_W-1:0]       root_o,
  output logic [IN_W-1:0]       ax_o,
  output logic [IN_W-1:0]       ay_o
);
  import v2n_pkg::*;

  localparam int unsigned RW = IN_W + 2;
  localparam int unsigned SW = IN_W + 4;

  v2n_tag_t          tag_q;
  logic [2*IN_W-1:0] rad_q;
  logic [RW-1:0]     rem_q, rem_d;
  logic [IN_W-1:0]   root_q, root_d;
  logic [IN_W-1:0]   ax_q, ay_q;
  logic [SW-1:0]     rem_sh, trial, rem_sub;
  logic              ge;

  // One root digit: bring down two radicand bits, try (4*root + 1).
  assign rem_sh  = {rem_i, rad_i[2*IN_W-1 -: 2]};
  assign trial   = {2'b00, root_i, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;
  assign rem_d   = ge ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
  assign root_d  = {root_i[IN_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (en_i) begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= {rad_i[2*IN_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
      ax_q   <= ax_i;
      ay_q   <= ay_i;
    end
  end

  assign tag_o  = tag_q;
  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign ax_o   = ax_q;
  assign ay_o   = ay_q;

endmodule

@@ rtl/v2n_div_cell.sv @@
module v2n_div_cell #(
  parameter int unsigned IN_W      = 24,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  v2n_pkg::v2n_tag_t     tag_i,
  input  logic [IN_W-1:0]       div_i,
  input  logic [IN_W-1:0]       rem_x_i,
  input  logic [IN_W-1:0]       rem_y_i,
  input  logic [FRAC_BITS:0]    q_x_i,
  input  logic [FRAC_BITS:0]    q_y_i,
  input  logic [IN_W-1:0]       ax_i,
  input  logic [IN_W-1:0]       ay_i,
  output v2n_pkg::v2n_tag_t     tag_o,
  output logic [IN_W-1:0]       div_o,
  output logic [IN_W-1:0]       rem_x_o,
  output logic [IN_W-1:0]       rem_y_o,
  output logic [FRAC_BITS:0]    q_x_o,
  output logic [FRAC_BITS:0]    q_y_o,
  output logic [IN_W-1:0]       ax_o,
  output logic [IN_W-1:0]       ay_o
);
  import v2n_pkg::*;

  v2n_tag_t         tag_q;
  logic [IN_W-1:0]  div_q, ax_q, ay_q;
  logic [IN_W-1:0]  rem_x_q, rem_y_q, rem_x_d, rem_y_d;
  logic [FRAC_BITS:0] q_x_q, q_y_q, q_x_d, q_y_d;
  logic [IN_W:0]    sh_x, sh_y, sub_x, sub_y, div_ext;
  logic             ge_x, ge_y;

  // One restoring quotient bit per lane; both lanes share the divisor.
  assign div_ext = {1'b0, div_i};
  assign sh_x    = {rem_x_i, 1'b0};
  assign sh_y    = {rem_y_i, 1'b0};
  assign ge_x    = sh_x >= div_ext;
  assign ge_y    = sh_y >= div_ext;
  assign sub_x   = sh_x - div_ext;
  assign sub_y   = sh_y - div_ext;
  assign rem_x_d = ge_x ? sub_x[IN_W-1:0] : sh_x[IN_W-1:0];
  assign rem_y_d = ge_y ? sub_y[IN_W-1:0] : sh_y[IN_W-1:0];
  assign q_x_d   = {q_x_i[FRAC_BITS-1:0], ge_x};
  assign q_y_d   = {q_y_i[FRAC_BITS-1:0], ge_y};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (en_i) begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q   <= div_i;
      rem_x_q <= rem_x_d;
      rem_y_q <= rem_y_d;
      q_x_q   <= q_x_d;
      q_y_q   <= q_y_d;
      ax_q    <= ax_i;
      ay_q    <= ay_i;
    end
  end

  assign tag_o   = tag_q;
  assign div_o   = div_q;
  assign rem_x_o = rem_x_q;
  assign rem_y_o = rem_y_q;
  assign q_x_o   = q_x_q;
  assign q_y_o   = q_y_q;
  assign ax_o    = ax_q;
  assign ay_o    = ay_q;

endmodule

@@ rtl/vector2_normalize_unit.sv @@
// Channel  Handshake              Payload
// in       in_valid_i/in_ready_o  in_x_i, in_y_i
// out      out_valid_o/out_ready_i unit_x_o, unit_y_o, degenerate_o
// cfg      APB psel/penable       paddr, pwdata, prdata (tolerance at 0x0)
//
// One beat enters per cycle while the output beat is not stalled.
// Latency is set by the square root chain (one cell per root bit) and the
// divider chain (one cell per fraction bit) plus six front and back stages.
// Reset clears all valid bits and sets tolerance to one LSB.
// A stalled output beat freezes the whole pipeline until it is taken.
`include "vector2_normalize_unit_macros.svh"

module vector2_normalize_unit #(
  parameter int unsigned FRAC_BITS = v2n_pkg::FRAC_BITS_DEF,
  parameter int unsigned INT_BITS  = v2n_pkg::INT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [INT_BITS+FRAC_BITS-1:0] in_x_i,
  input  logic signed [INT_BITS+FRAC_BITS-1:0] in_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [FRAC_BITS+1:0]         unit_x_o,
  output logic signed [FRAC_BITS+1:0]         unit_y_o,
  output logic                                degenerate_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [v2n_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [v2n_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [v2n_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import v2n_pkg::*;

  localparam int unsigned IN_W  = INT_BITS + FRAC_BITS;
  localparam int unsigned OUT_W = FRAC_BITS + 2;
  localparam int unsigned Q_W   = FRAC_BITS + 1;
  localparam int unsigned SQ_W  = 2 * IN_W;
  localparam int unsigned HB    = IN_W / 2;
  localparam int unsigned HH    = IN_W - HB;
  localparam logic [IN_W-1:0] ONE_Q = IN_W'(1) << FRAC_BITS;

  // ---------------- configuration ----------------
  logic [TOL_W-1:0]           tol_q;
  logic                       reg_hit;
  logic [TOL_W+FRAC_BITS-1:0] tol_wide;
  logic [FRAC_BITS-1:0]       tol_s;
  logic [IN_W-1:0]            tol_ext;

  assign reg_hit = paddr[APB_ADDR_W-1:2] == REG_TOLERANCE;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? APB_DATA_W'(tol_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      tol_q <= pwdata[TOL_W-1:0];
    end
  end

  // Rescale Q0.16 to FRAC_BITS fraction bits, truncating when narrower.
  assign tol_wide = {tol_q, {FRAC_BITS{1'b0}}};
  assign tol_s    = tol_wide[TOL_W+FRAC_BITS-1:TOL_W];
  assign tol_ext  = IN_W'(tol_s);

  // ---------------- global advance ----------------
  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // ---------------- stage A: magnitudes and signs ----------------
  v2n_tag_t        a_tag_q, a_tag_d;
  logic [IN_W-1:0] a_ax_q, a_ay_q, x_u, y_u, abs_x, abs_y;

  assign x_u   = in_x_i;
  assign y_u   = in_y_i;
  assign abs_x = x_u[IN_W-1] ? (~x_u + 1'b1) : x_u;
  assign abs_y = y_u[IN_W-1] ? (~y_u + 1'b1) : y_u;

  always_comb begin
    a_tag_d       = '0;
    a_tag_d.valid = in_valid_i;
    a_tag_d.neg_x = x_u[IN_W-1];
    a_tag_d.neg_y = y_u[IN_W-1];
  end

  // ---------------- stage B: half-width partial products ----------------
  v2n_tag_t          b_tag_q;
  logic [IN_W-1:0]   b_ax_q, b_ay_q;
  logic [2*HH-1:0]   b_xhh_q, b_yhh_q;
  logic [HH+HB-1:0]  b_xhl_q, b_yhl_q;
  logic [2*HB-1:0]   b_xll_q, b_yll_q;

  // ---------------- stage C: squares ----------------
  v2n_tag_t        c_tag_q;
  logic [IN_W-1:0] c_ax_q, c_ay_q;
  logic [SQ_W-1:0] c_sqx_q, c_sqy_q;

  // ---------------- stage S: sum of squares ----------------
  v2n_tag_t        s_tag_q;
  logic [IN_W-1:0] s_ax_q, s_ay_q;
  logic [SQ_W-1:0] s_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_tag_q <= '0;
      b_tag_q <= '0;
      c_tag_q <= '0;
      s_tag_q <= '0;
    end else if (en) begin
      a_tag_q <= a_tag_d;
      b_tag_q <= a_tag_q;
      c_tag_q <= b_tag_q;
      s_tag_q <= c_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ax_q  <= abs_x;
      a_ay_q  <= abs_y;
      b_ax_q  <= a_ax_q;
      b_ay_q  <= a_ay_q;
      b_xhh_q <= a_ax_q[IN_W-1:HB] * a_ax_q[IN_W-1:HB];
      b_xhl_q <= a_ax_q[IN_W-1:HB] * a_ax_q[HB-1:0];
      b_xll_q <= a_ax_q[HB-1:0] * a_ax_q[HB-1:0];
      b_yhh_q <= a_ay_q[IN_W-1:HB] * a_ay_q[IN_W-1:HB];
      b_yhl_q <= a_ay_q[IN_W-1:HB] * a_ay_q[HB-1:0];
      b_yll_q <= a_ay_q[HB-1:0] * a_ay_q[HB-1:0];
      c_ax_q  <= b_ax_q;
      c_ay_q  <= b_ay_q;
      c_sqx_q <= (SQ_W'(b_xhh_q) << (2 * HB)) + (SQ_W'(b_xhl_q) << (HB + 1))
                 + SQ_W'(b_xll_q);
      c_sqy_q <= (SQ_W'(b_yhh_q) << (2 * HB)) + (SQ_W'(b_yhl_q) << (HB + 1))
                 + SQ_W'(b_yll_q);
      s_ax_q  <= c_ax_q;
      s_ay_q  <= c_ay_q;
      s_sum_q <= c_sqx_q + c_sqy_q;
    end
  end

  // ---------------- square root chain ----------------
  v2n_tag_t        sq_tag  [IN_W+1];
  logic [SQ_W-1:0] sq_rad  [IN_W+1];
  logic [IN_W+1:0] sq_rem  [IN_W+1];
  logic [IN_W-1:0] sq_root [IN_W+1];
  logic [IN_W-1:0] sq_ax   [IN_W+1];
  logic [IN_W-1:0] sq_ay   [IN_W+1];

  assign sq_tag[0]  = s_tag_q;
  assign sq_rad[0]  = s_sum_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_ax[0]   = s_ax_q;
  assign sq_ay[0]   = s_ay_q;

  for (genvar g = 0; g < IN_W; g++) begin : g_sqrt
    v2n_sqrt_cell #(
      .IN_W(IN_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .tag_i  (sq_tag[g]),
      .rad_i  (sq_rad[g]),
      .rem_i  (sq_rem[g]),
      .root_i (sq_root[g]),
      .ax_i   (sq_ax[g]),
      .ay_i   (sq_ay[g]),
      .tag_o  (sq_tag[g+1]),
      .rad_o  (sq_rad[g+1]),
      .rem_o  (sq_rem[g+1]),
      .root_o (sq_root[g+1]),
      .ax_o   (sq_ax[g+1]),
      .ay_o   (sq_ay[g+1])
    );
  end

  // ---------------- stage D: degenerate test and integer quotient bit ----------------
  v2n_tag_t        d_tag_q, d_tag_d;
  logic [IN_W-1:0] d_div_q, d_ax_q, d_ay_q, d_rem_x_q, d_rem_y_q;
  logic            d_q_x_q, d_q_y_q;
  logic [IN_W-1:0] mag, first_rem_x, first_rem_y;
  logic            first_q_x, first_q_y;

  assign mag         = sq_root[IN_W];
  assign first_q_x   = sq_ax[IN_W] >= mag;
  assign first_q_y   = sq_ay[IN_W] >= mag;
  assign first_rem_x = first_q_x ? (sq_ax[IN_W] - mag) : sq_ax[IN_W];
  assign first_rem_y = first_q_y ? (sq_ay[IN_W] - mag) : sq_ay[IN_W];

  always_comb begin
    d_tag_d       = sq_tag[IN_W];
    d_tag_d.degen = mag <= tol_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_tag_q <= '0;
    end else if (en) begin
      d_tag_q <= d_tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_div_q   <= mag;
      d_ax_q    <= sq_ax[IN_W];
      d_ay_q    <= sq_ay[IN_W];
      d_rem_x_q <= first_rem_x;
      d_rem_y_q <= first_rem_y;
      d_q_x_q   <= first_q_x;
      d_q_y_q   <= first_q_y;
    end
  end

  // ---------------- fraction divider chain ----------------
  v2n_tag_t        dv_tag   [FRAC_BITS+1];
  logic [IN_W-1:0] dv_div   [FRAC_BITS+1];
  logic [IN_W-1:0] dv_rem_x [FRAC_BITS+1];
  logic [IN_W-1:0] dv_rem_y [FRAC_BITS+1];
  logic [Q_W-1:0]  dv_q_x   [FRAC_BITS+1];
  logic [Q_W-1:0]  dv_q_y   [FRAC_BITS+1];
  logic [IN_W-1:0] dv_ax    [FRAC_BITS+1];
  logic [IN_W-1:0] dv_ay    [FRAC_BITS+1];

  assign dv_tag[0]   = d_tag_q;
  assign dv_div[0]   = d_div_q;
  assign dv_rem_x[0] = d_rem_x_q;
  assign dv_rem_y[0] = d_rem_y_q;
  assign dv_q_x[0]   = Q_W'(d_q_x_q);
  assign dv_q_y[0]   = Q_W'(d_q_y_q);
  assign dv_ax[0]    = d_ax_q;
  assign dv_ay[0]    = d_ay_q;

  for (genvar g = 0; g < FRAC_BITS; g++) begin : g_div
    v2n_div_cell #(
      .IN_W      (IN_W),
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .tag_i   (dv_tag[g]),
      .div_i   (dv_div[g]),
      .rem_x_i (dv_rem_x[g]),
      .rem_y_i (dv_rem_y[g]),
      .q_x_i   (dv_q_x[g]),
      .q_y_i   (dv_q_y[g]),
      .ax_i    (dv_ax[g]),
      .ay_i    (dv_ay[g]),
      .tag_o   (dv_tag[g+1]),
      .div_o   (dv_div[g+1]),
      .rem_x_o (dv_rem_x[g+1]),
      .rem_y_o (dv_rem_y[g+1]),
      .q_x_o   (dv_q_x[g+1]),
      .q_y_o   (dv_q_y[g+1]),
      .ax_o    (dv_ax[g+1]),
      .ay_o    (dv_ay[g+1])
    );
  end

  // ---------------- output stage ----------------
  // Degenerate vectors pass the input through; small components flush to
  // zero, then the magnitude is clamped to one and the sign is restored.
  function automatic logic [OUT_W-1:0] pack_lane(
    input logic            neg,
    input logic            degen,
    input logic [IN_W-1:0] a,
    input logic [Q_W-1:0]  q,
    input logic [IN_W-1:0] tol
  );
    logic [IN_W-1:0]  sel;
    logic [OUT_W-1:0] m;
    sel = degen ? a : IN_W'(q);
    if (sel < tol) begin
      sel = '0;
    end
    if (sel > ONE_Q) begin
      m = ONE_Q[OUT_W-1:0];
    end else begin
      m = sel[OUT_W-1:0];
    end
    return neg ? (~m + 1'b1) : m;
  endfunction

  v2n_tag_t         last_tag;
  logic [OUT_W-1:0] unit_x_q, unit_y_q, unit_x_d, unit_y_d;
  logic             degen_q;

  assign last_tag = dv_tag[FRAC_BITS];
  assign unit_x_d = pack_lane(last_tag.neg_x, last_tag.degen, dv_ax[FRAC_BITS],
                              dv_q_x[FRAC_BITS], tol_ext);
  assign unit_y_d = pack_lane(last_tag.neg_y, last_tag.degen, dv_ay[FRAC_BITS],
                              dv_q_y[FRAC_BITS], tol_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= last_tag.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      unit_x_q <= unit_x_d;
      unit_y_q <= unit_y_d;
      degen_q  <= last_tag.degen;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign unit_x_o     = unit_x_q;
  assign unit_y_o     = unit_y_q;
  assign degenerate_o = degen_q;

  // ---------------- assertions ----------------
  `V2N_ASSERT_IMPL(a_stall_blocks_input, clk_i, rst_ni, out_valid_q && !out_ready_i, !in_ready_o, "input taken while output beat is stalled")
  `V2N_ASSERT_IMPL(a_root_covers_parts, clk_i, rst_ni, sq_tag[IN_W].valid, (sq_ax[IN_W] <= mag) && (sq_ay[IN_W] <= mag), "square root smaller than a component")
  `V2N_ASSERT_IMPL(a_div_rem_bounded, clk_i, rst_ni, last_tag.valid && !last_tag.degen, (dv_rem_x[FRAC_BITS] < dv_div[FRAC_BITS]) && (dv_rem_y[FRAC_BITS] < dv_div[FRAC_BITS]), "divider remainder not below divisor")
  `V2N_ASSERT_NEXT(a_result_reaches_out, clk_i, rst_ni, en && last_tag.valid, out_valid_q, "finished beat did not reach output register")
  `V2N_ASSERT_IMPL(a_unit_in_range, clk_i, rst_ni, out_valid_q, !(unit_x_q[OUT_W-1] && !unit_x_q[OUT_W-2]) && !(unit_y_q[OUT_W-1] && !unit_y_q[OUT_W-2]), "unit component below minus one")

endmodule
